/* design/cnf_pkg.sv */
`default_nettype none

package cnf_pkg;

	localparam int MAX_LEN_DEF = 1024;
	localparam int ELEM_W      = 16;
	localparam int MIN_W       = 11;
	localparam int CURL_W      = 11;
	localparam int PERIOD_W    = 10;

	typedef struct packed {
		logic signed [ELEM_W-1:0] element;
		logic                     last;
		logic [MIN_W-1:0]         min_curl;
	} in_t;

	typedef struct packed {
		logic [CURL_W-1:0]   curl;
		logic [PERIOD_W-1:0] period;
		logic                found;
		logic                overflow;
	} out_t;

	// bank handed back by the search side when its job is done
	typedef struct packed {
		logic en;
		logic bank;
	} rel_t;

endpackage

`default_nettype wire

/* design/cnf_queue.sv */
`default_nettype none

module cnf_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              empty,
	output logic              full
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign empty    = (count_q == 2'd0);
	assign full     = (count_q == 2'd2);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 2'd1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !push) |=> (count_q == $past(count_q) - 2'd1))
		else $error("queue count did not drop on pop");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != 2'd3))
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with a full count");

endmodule

`default_nettype wire

/* design/cnf_front.sv */
`default_nettype none

module cnf_front #(
	parameter int MAX_LEN = 1024,
	parameter int CW      = 11,
	parameter int AW      = 10,
	parameter int JW      = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_stall,
	input  wire cnf_pkg::in_t item,
	input  wire cnf_pkg::rel_t rel,
	output logic              wr_en,
	output logic [AW:0]       wr_addr,
	output logic [15:0]       wr_data,
	output logic              job_push,
	output logic [JW-1:0]     job_data
);

	import cnf_pkg::*;

	typedef struct packed {
		logic             bank;
		logic             ovf;
		logic [MIN_W-1:0] min_curl;
		logic [CW-1:0]    len;
	} job_t;

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          wb_q;
	logic [1:0]    bank_busy_q;
	logic [1:0]    busy_d;
	logic          accept;
	logic          store_full;
	job_t          job;

	assign item_stall = bank_busy_q[wb_q];
	assign accept     = item_valid && !item_stall;
	assign store_full = (cnt_q == CW'(MAX_LEN));

	assign wr_en   = accept && !store_full;
	assign wr_addr = {wb_q, cnt_q[AW-1:0]};
	assign wr_data = item.element;

	always_comb begin
		job.bank     = wb_q;
		job.ovf      = ovf_q | store_full;
		job.min_curl = item.min_curl;
		job.len      = store_full ? cnt_q : cnt_q + CW'(1);
	end

	assign job_push = accept && item.last;
	assign job_data = job;

	// bank in use flags: release from the back, claim on a last transaction
	always_comb begin
		busy_d = bank_busy_q;
		if (rel.en) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (accept && item.last) begin
			busy_d[wb_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			wb_q        <= 1'b0;
			bank_busy_q <= 2'b00;
		end else begin
			bank_busy_q <= busy_d;
			if (accept) begin
				if (item.last) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
					wb_q  <= ~wb_q;
				end else if (store_full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.last) |=> bank_busy_q[$past(wb_q)] && (cnt_q == '0))
		else $error("last transaction did not close its bank");
	assert property (@(posedge clk) disable iff (!arst_n)
		rel.en |-> bank_busy_q[rel.bank])
		else $error("release of a bank that was not in use");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CW'(MAX_LEN)))
		else $error("element count beyond capacity");

endmodule

`default_nettype wire

/* design/cnf_back.sv */
`default_nettype none

module cnf_back #(
	parameter int CW      = 11,
	parameter int AW      = 10,
	parameter int JW      = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [AW:0]   wr_addr,
	input  wire logic [15:0]   wr_data,
	input  wire logic [JW-1:0] job_data,
	input  wire logic          job_empty,
	output logic               job_pop,
	output cnf_pkg::rel_t      rel,
	output logic               result_valid,
	input  wire logic          result_stall,
	output cnf_pkg::out_t      result
);

	import cnf_pkg::*;

	localparam int KW  = (CW > CURL_W) ? CW : CURL_W;
	localparam int DW  = KW + 1;
	localparam int PW  = CW + DW;
	localparam int PDW = (CW > PERIOD_W) ? CW : PERIOD_W;
	localparam int MD  = 2 * (2 ** AW);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LIM  = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_FCHK = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_CMP  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	typedef struct packed {
		logic             bank;
		logic             ovf;
		logic [MIN_W-1:0] min_curl;
		logic [CW-1:0]    len;
	} job_t;

	logic [15:0]    mem [MD];
	logic [15:0]    rd_a_q;
	logic [15:0]    rd_b_q;
	logic [2:0]     state_q;
	logic [CW-1:0]  len_q;
	logic [DW-1:0]  d_q;
	logic [KW-1:0]  curl_q;
	logic [PDW-1:0] period_q;
	logic           found_q;
	logic           ovf_q;
	logic           bank_q;
	logic [CW-1:0]  i_q;
	logic [CW-1:0]  freq_q;
	logic [CW:0]    off_q;
	logic [CW-1:0]  k_q;
	logic [PW-1:0]  prod_q;
	logic           out_valid_q;
	out_t           out_q;
	job_t           job;
	logic [MIN_W-1:0] job_min;
	logic [CW-1:0]  addr_a;
	logic [CW:0]    addr_b;
	logic           out_free;

	assign job     = job_t'(job_data);
	assign job_min = (job.min_curl == '0) ? MIN_W'(1) : job.min_curl;
	assign addr_a  = len_q - i_q + k_q;
	assign addr_b  = {1'b0, len_q} - off_q + {1'b0, k_q};
	assign out_free = !out_valid_q || !result_stall;

	assign job_pop      = (state_q == S_IDLE) && !job_empty;
	assign rel.en       = (state_q == S_DONE) && out_free;
	assign rel.bank     = bank_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (state_q == S_RD) begin
			rd_a_q <= mem[{bank_q, addr_a[AW-1:0]}];
			rd_b_q <= mem[{bank_q, addr_b[AW-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q.curl     <= curl_q[CURL_W-1:0];
			out_q.period   <= period_q[PERIOD_W-1:0];
			out_q.found    <= found_q;
			out_q.overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			len_q       <= '0;
			d_q         <= '0;
			curl_q      <= '0;
			period_q    <= '0;
			found_q     <= 1'b0;
			ovf_q       <= 1'b0;
			bank_q      <= 1'b0;
			i_q         <= '0;
			freq_q      <= '0;
			off_q       <= '0;
			k_q         <= '0;
			prod_q      <= '0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!job_empty) begin
						len_q    <= job.len;
						ovf_q    <= job.ovf;
						bank_q   <= job.bank;
						d_q      <= DW'(job_min);
						curl_q   <= KW'(job_min - MIN_W'(1));
						period_q <= '0;
						found_q  <= 1'b0;
						i_q      <= CW'(1);
						state_q  <= S_LIM;
					end
				end
				S_LIM: begin
					prod_q  <= PW'(i_q) * PW'(d_q);
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (prod_q <= PW'(len_q)) begin
						freq_q  <= CW'(2);
						off_q   <= {i_q, 1'b0};
						state_q <= S_FCHK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FCHK: begin
					if (off_q <= {1'b0, len_q}) begin
						k_q     <= '0;
						state_q <= S_RD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_LIM;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rd_a_q != rd_b_q) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_LIM;
					end else if ((k_q + CW'(1)) == i_q) begin
						if (curl_q < KW'(freq_q)) begin
							curl_q   <= KW'(freq_q);
							d_q      <= DW'(freq_q) + DW'(1);
							period_q <= PDW'(i_q);
							found_q  <= 1'b1;
						end
						freq_q  <= freq_q + CW'(1);
						off_q   <= off_q + {1'b0, i_q};
						state_q <= S_FCHK;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ($past(state_q) == S_RD))
		else $error("compare without a preceding read");
	assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (curl_q >= KW'(2)) && (period_q != '0))
		else $error("found result without a repeat");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !found_q) |-> (period_q == '0))
		else $error("period set on a result that was not found");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (k_q < i_q) && (off_q <= {1'b0, len_q}))
		else $error("read outside the block being compared");

endmodule

`default_nettype wire

/* design/curling_number_finder.sv */
`default_nettype none

// Loads one sequence element per cycle, while item_stall is low, into one of
// two memory banks; the item flagged last closes the sequence and queues a
// search job, after which loading of the next sequence goes on at one element
// per cycle in the other bank once that bank is free. The search reads both
// compared elements in the same memory cycle; it steps through S_LIM and S_CHK
// for each block length tried, S_FCHK for each repeat count tried, and S_RD
// and S_CMP for each element compared. With both banks holding unfinished
// sequences, item_stall is high until the older search has handed its result
// to the output register.

module curling_number_finder #(
	parameter int MAX_LEN = cnf_pkg::MAX_LEN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire cnf_pkg::in_t  item,
	output logic               result_valid,
	input  wire logic          result_stall,
	output cnf_pkg::out_t      result
);

	import cnf_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);
	localparam int JW = 2 + MIN_W + CW;

	logic          wr_en;
	logic [AW:0]   wr_addr;
	logic [15:0]   wr_data;
	logic          job_push;
	logic [JW-1:0] job_push_data;
	logic [JW-1:0] job_pop_data;
	logic          job_pop;
	logic          job_empty;
	logic          job_full;
	rel_t          rel;

	cnf_front #(
		.MAX_LEN(MAX_LEN),
		.CW(CW),
		.AW(AW),
		.JW(JW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.rel(rel),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.job_push(job_push),
		.job_data(job_push_data)
	);

	cnf_queue #(
		.W(JW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.push_data(job_push_data),
		.pop(job_pop),
		.pop_data(job_pop_data),
		.empty(job_empty),
		.full(job_full)
	);

	cnf_back #(
		.CW(CW),
		.AW(AW),
		.JW(JW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.job_data(job_pop_data),
		.job_empty(job_empty),
		.job_pop(job_pop),
		.rel(rel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("search job queued while the queue is full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid && $stable(result))
		else $error("stalled result transaction changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_full |-> item_stall)
		else $error("transaction taken with both banks waiting");

endmodule

`default_nettype wire

/* sim/cnf_checker.sv */
`timescale 1ns / 1ps

module cnf_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	input  wire logic          item_stall,
	input  wire cnf_pkg::in_t  item,
	input  wire logic          result_valid,
	input  wire logic          result_stall,
	input  wire cnf_pkg::out_t result,
	output int                 errors,
	output int                 pending
);

	import cnf_pkg::*;

	localparam int MAX_LEN = MAX_LEN_DEF;

	logic [ELEM_W-1:0] seq_mem [MAX_LEN];
	int unsigned       seq_len;
	logic              dropped;
	out_t              curl_q [$];
	out_t              want;
	int                err_cnt;

	function automatic out_t find_curl(int unsigned len, int unsigned min_c, logic ovf);
		int unsigned best, bound, per, i, rep, k;
		logic        fnd, same;
		out_t        r;
		if (min_c == 0)
			min_c = 1;
		best = min_c - 1;
		bound = len / min_c;
		per = 0;
		fnd = 1'b0;
		for (i = 1; i <= bound; i++) begin
			rep = 2;
			while (rep * i <= len) begin
				same = 1'b1;
				for (k = 0; k < i && same; k++)
					if (seq_mem[len - i + k] != seq_mem[len - rep * i + k])
						same = 1'b0;
				if (!same)
					break;
				if (best < rep) begin
					best = rep;
					bound = len / (best + 1);
					per = i;
					fnd = 1'b1;
				end
				rep++;
			end
		end
		r.curl = best[CURL_W-1:0];
		r.period = per[PERIOD_W-1:0];
		r.found = fnd;
		r.overflow = ovf;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len = 0;
			dropped = 1'b0;
			curl_q.delete();
			err_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				if (seq_len < MAX_LEN) begin
					seq_mem[seq_len] = item.element;
					seq_len++;
				end else begin
					dropped = 1'b1;
				end
				if (item.last) begin
					curl_q = {curl_q, find_curl(seq_len, 32'(item.min_curl), dropped)};
					seq_len = 0;
					dropped = 1'b0;
				end
			end
			if (result_valid && !result_stall) begin
				if (curl_q.size() == 0) begin
					$error("unexpected result transaction");
					err_cnt++;
				end else begin
					want = curl_q.pop_front();
					if (result.curl !== want.curl) begin
						$error("curl: expected %0d, actual %0d", want.curl, result.curl);
						err_cnt++;
					end
					if (result.period !== want.period) begin
						$error("period: expected %0d, actual %0d", want.period, result.period);
						err_cnt++;
					end
					if (result.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, result.found);
						err_cnt++;
					end
					if (result.overflow !== want.overflow) begin
						$error("overflow: expected %0d, actual %0d", want.overflow,
							result.overflow);
						err_cnt++;
					end
				end
			end
			errors <= err_cnt;
			pending <= curl_q.size();
		end
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import cnf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_t  item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result;
	int   errors;
	int   pending;

	logic [ELEM_W-1:0] seq_q [$];
	logic [ELEM_W-1:0] palette [3];
	logic [ELEM_W-1:0] blk [6];
	int                pal_n;
	int                burst_left = 0;

	curling_number_finder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	cnf_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.errors       (errors),
		.pending      (pending)
	);

	always #10 clk = ~clk;

	initial begin
		#10ms;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic logic [ELEM_W-1:0] rand_elem();
		if (pal_n == 0)
			return ELEM_W'($urandom);
		return palette[$urandom_range(0, pal_n - 1)];
	endfunction

	task automatic send_item(input in_t x);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item <= x;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic send_sequence(input logic [MIN_W-1:0] mc);
		in_t x;
		for (int j = 0; j < seq_q.size(); j++) begin
			x.element = seq_q[j];
			x.last = (j == seq_q.size() - 1);
			x.min_curl = x.last ? mc : MIN_W'($urandom);
			send_item(x);
		end
	endtask

	// receiver stall pattern, with one long hold-off
	initial begin
		int rx_cycle;
		int mode;
		rx_cycle = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(16, 96)) begin
				@(posedge clk);
				rx_cycle++;
				if (rx_cycle == 200) begin
					result_stall <= 1'b1;
					repeat (1000) @(posedge clk);
				end
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= 1'($urandom_range(0, 1));
					default: result_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	initial begin
		int                rand_items;
		int                len;
		int                per;
		int                pre;
		int                sel;
		logic [MIN_W-1:0]  mc;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		seq_q = '{16'h8000};
		send_sequence(11'd1);
		seq_q = '{16'h7FFF, 16'h7FFF};
		send_sequence(11'd0);
		seq_q = '{16'd5, 16'hFFFF, 16'd5, 16'hFFFF, 16'd5, 16'hFFFF};
		send_sequence(11'd2);
		seq_q = '{16'd7, 16'd7, 16'd7};
		send_sequence(11'd5);
		seq_q = '{16'd1, 16'd2, 16'd3, 16'd4};
		send_sequence(11'd1);
		seq_q = '{16'd3, 16'd3};
		send_sequence(11'd1023);
		seq_q = '{16'd9};
		send_sequence(11'd1024);
		seq_q = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000};
		send_sequence(11'd1);

		rand_items = 0;
		while (rand_items < 400) begin
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
			pal_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
			foreach (palette[j])
				palette[j] = ELEM_W'($urandom);
			per = $urandom_range(1, 6);
			pre = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, len - 1);
			for (int j = 0; j < per; j++)
				blk[j] = rand_elem();
			seq_q.delete();
			if ($urandom_range(0, 4) == 0) begin
				for (int j = 0; j < len; j++)
					seq_q = {seq_q, rand_elem()};
			end else begin
				for (int j = 0; j < len; j++)
					seq_q = {seq_q, ((j < pre) ? rand_elem() : blk[(j - pre) % per])};
				if ($urandom_range(0, 4) == 0)
					seq_q[$urandom_range(0, len - 1)] = ELEM_W'($urandom);
			end
			sel = $urandom_range(0, 9);
			case (sel)
				0: mc = '0;
				1, 2, 3, 4, 5: mc = MIN_W'($urandom_range(1, 3));
				6, 7: mc = MIN_W'($urandom_range(2, 12));
				8: mc = MIN_W'($urandom_range(1, 1024));
				default: mc = 11'd1;
			endcase
			send_sequence(mc);
			rand_items += len;
		end

		// period of half the store, then more elements than the store holds
		seq_q.delete();
		for (int j = 0; j < MAX_LEN_DEF / 2; j++)
			seq_q = {seq_q, ELEM_W'($urandom)};
		for (int j = 0; j < MAX_LEN_DEF / 2; j++)
			seq_q = {seq_q, seq_q[j]};
		for (int j = 0; j < 6; j++)
			seq_q = {seq_q, ELEM_W'($urandom)};
		send_sequence(11'd1);

		seq_q = '{16'h1111, 16'h1111};
		send_sequence(11'd1);

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
design/cnf_pkg.sv
design/cnf_queue.sv
design/cnf_front.sv
design/cnf_back.sv
design/curling_number_finder.sv
sim/cnf_checker.sv
sim/tb_top.sv
